>>> rtl/gaussian_pdf_four_lane_unit_defines.svh
// Assertion macros for the four-lane normal density unit.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef GAUSSIAN_PDF_FOUR_LANE_UNIT_DEFINES_SVH
`define GAUSSIAN_PDF_FOUR_LANE_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define GPDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpdf check failed");

// Next-cycle implication, quiet during reset.
`define GPDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpdf check failed");

`endif

>>> rtl/gpdf_pkg.sv
// Types, constants and the 2^(-i/16) table for the normal density unit.
// No dependencies.
package gpdf_pkg;

  localparam int LANES     = 4;
  localparam int FRAC_BITS = 8;
  localparam int TQ_BITS   = 22;               // quotient bits of the exponent divide
  localparam int NUM_W     = 40 + FRAC_BITS;   // dividend width of the final divide

  localparam logic [21:0] T_CAP    = 22'd3145728;   // 48.0 in Q.16
  localparam logic [16:0] LOG2E    = 17'd94548;
  localparam logic [22:0] INV_S2PI = 23'd6693141;
  localparam logic [23:0] PDF_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [15:0] x3;
    logic signed [15:0] mean;
    logic        [15:0] std_dev;
  } gpdf_in_t;

  typedef struct packed {
    logic [23:0] pdf0;
    logic [23:0] pdf1;
    logic [23:0] pdf2;
    logic [23:0] pdf3;
    logic        saturated;
  } gpdf_out_t;

  // 2^(-i/16) in Q.16
  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/gaussian_pdf_four_lane_unit.sv
// Four-lane fixed-point normal density, fully pipelined.
// Uses gpdf_pkg and gaussian_pdf_four_lane_unit_defines.svh.
//
// One item (four samples, a mean and a deviation) enters every cycle while
// stall_o is low. The pipeline depth is set by two restoring dividers, one
// quotient bit per stage: 22 stages for the scaled exponent (d^2 / 2sd^2)
// and 48 stages for the division of the scaled exponential by sd, plus nine
// stages of difference, squaring, log2(e) scaling, table interpolation, the
// 1/sqrt(2pi) multiply, the power-of-two shift and the final rounding. A
// stall on the output while valid_o is high freezes the whole pipe; nothing
// is lost or repeated.
`include "gaussian_pdf_four_lane_unit_defines.svh"

module gaussian_pdf_four_lane_unit
  import gpdf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  gpdf_in_t  data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output gpdf_out_t data_o
);

  localparam int D1   = TQ_BITS;
  localparam int D2   = NUM_W;
  localparam int S_U  = 3 + D1;       // stage index of the log2(e) product
  localparam int S_SH = S_U + 4;      // stage index of the shifted numerator
  localparam int NV   = S_SH + 1 + D2;

  logic adv;
  logic [NV-1:0] vld_q;
  logic out_valid_q;
  gpdf_out_t out_q;

  assign stall_o = out_valid_q && stall_i;
  assign adv     = !stall_o;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // shared deviation, carried with each item
  logic [15:0] s_q [NV];

  // front stages
  logic [LANES-1:0][15:0] ad_q;
  logic [LANES-1:0][31:0] d2_q;
  logic [32:0] den0_q;

  // exponent divider
  logic [LANES-1:0][32:0] r1_q   [D1+1];
  logic [LANES-1:0][21:0] nlo_q  [D1+1];
  logic [LANES-1:0][21:0] q1_q   [D1+1];
  logic [LANES-1:0]       ovf_q  [D1+1];
  logic [32:0]            den_q  [D1+1];

  // exponential
  logic [LANES-1:0][22:0] u_q;
  logic [LANES-1:0][6:0]  k1_q, k2_q, k3_q;
  logic [LANES-1:0][16:0] ta_q;
  logic [LANES-1:0][23:0] prod_q;
  logic [LANES-1:0][16:0] m_q;
  logic [LANES-1:0][39:0] num_q;

  // final divider
  logic [LANES-1:0][15:0]      r2_q [D2+1];
  logic [LANES-1:0][NUM_W-1:0] n2_q [D2+1];
  logic [LANES-1:0][NUM_W-1:0] q2_q [D2+1];

  logic signed [15:0] xs [LANES];
  assign xs[0] = data_i.x0;
  assign xs[1] = data_i.x1;
  assign xs[2] = data_i.x2;
  assign xs[3] = data_i.x3;

  // next values
  logic [LANES-1:0][15:0] ad_d;
  logic [15:0] s_d;
  logic [LANES-1:0][32:0] r1_d  [D1+1];
  logic [LANES-1:0][21:0] q1_d  [D1+1];
  logic [LANES-1:0]       ovf_d;
  logic [LANES-1:0][22:0] u_d;
  logic [LANES-1:0][16:0] ta_d;
  logic [LANES-1:0][23:0] prod_d;
  logic [LANES-1:0][16:0] m_d;
  logic [LANES-1:0][NUM_W-1:0] sh_d;
  logic [LANES-1:0][15:0]      r2_d [D2+1];
  logic [LANES-1:0][NUM_W-1:0] q2_d [D2+1];
  gpdf_out_t out_d;

  always_comb begin
    logic signed [16:0] dd;
    logic [33:0] try1;
    logic [21:0] tc;
    logic [39:0] up;
    logic [15:0] f;
    logic [16:0] tb;
    logic [16:0] try2;
    logic [NUM_W:0] qr;
    logic [24:0] res;
    logic [LANES-1:0] sat;
    logic [LANES-1:0][23:0] pdf;

    s_d = (data_i.std_dev == 16'd0) ? 16'd1 : data_i.std_dev;
    for (int l = 0; l < LANES; l++) begin
      dd = 17'({xs[l][15], xs[l]}) - 17'({data_i.mean[15], data_i.mean});
      ad_d[l] = dd[16] ? 16'(-dd) : 16'(dd);
    end

    // overflow check: quotient would not fit in TQ_BITS
    for (int l = 0; l < LANES; l++) begin
      ovf_d[l] = {8'd0, d2_q[l][31:6]} >= {1'b0, den0_q};
    end
    r1_d[0] = '0;
    q1_d[0] = '0;
    for (int j = 1; j <= D1; j++) begin
      for (int l = 0; l < LANES; l++) begin
        try1 = {r1_q[j-1][l], nlo_q[j-1][l][D1-j]};
        q1_d[j][l] = q1_q[j-1][l];
        if (try1 >= {1'b0, den_q[j-1]}) begin
          r1_d[j][l]         = 33'(try1 - {1'b0, den_q[j-1]});
          q1_d[j][l][D1-j]   = 1'b1;
        end else begin
          r1_d[j][l] = try1[32:0];
        end
      end
    end

    for (int l = 0; l < LANES; l++) begin
      if (ovf_q[D1][l] || q1_q[D1][l] > T_CAP) tc = T_CAP;
      else tc = q1_q[D1][l];
      up = 40'(tc) * 40'(LOG2E) + 40'd32768;
      u_d[l] = up[38:16];

      f = u_q[l][15:0];
      ta_d[l] = pow2_tab({1'b0, f[15:12]});
      tb = pow2_tab(5'({1'b0, f[15:12]}) + 5'd1);
      prod_d[l] = 12'(ta_d[l] - tb) * f[11:0];

      m_d[l] = ta_q[l] - 17'((25'(prod_q[l]) + 25'd2048) >> 12);

      sh_d[l] = k3_q[l][6] ? '0 : ({num_q[l], {FRAC_BITS{1'b0}}} >> k3_q[l][5:0]);
    end

    r2_d[0] = '0;
    q2_d[0] = '0;
    for (int j = 1; j <= D2; j++) begin
      for (int l = 0; l < LANES; l++) begin
        try2 = {r2_q[j-1][l], n2_q[j-1][l][D2-j]};
        q2_d[j][l] = q2_q[j-1][l];
        if (try2 >= {1'b0, s_q[S_SH+j-1]}) begin
          r2_d[j][l]       = 16'(try2 - {1'b0, s_q[S_SH+j-1]});
          q2_d[j][l][D2-j] = 1'b1;
        end else begin
          r2_d[j][l] = try2[15:0];
        end
      end
    end

    // round, then clamp
    for (int l = 0; l < LANES; l++) begin
      qr = {1'b0, q2_q[D2][l]} + (NUM_W+1)'(24'h800000);
      res = qr[48:24];
      sat[l] = res[24];
      pdf[l] = sat[l] ? PDF_MAX : res[23:0];
    end
    out_d.pdf0      = pdf[0];
    out_d.pdf1      = pdf[1];
    out_d.pdf2      = pdf[2];
    out_d.pdf3      = pdf[3];
    out_d.saturated = |sat;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NV-2:0], valid_i};
      out_valid_q <= vld_q[NV-1];
    end
  end

  // datapath, advance in lockstep with the valid chain
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= s_d;
      for (int i = 1; i < NV; i++) s_q[i] <= s_q[i-1];

      ad_q   <= ad_d;
      for (int l = 0; l < LANES; l++) d2_q[l] <= ad_q[l] * ad_q[l];
      den0_q <= {32'(s_q[0]) * 32'(s_q[0]), 1'b0};

      for (int l = 0; l < LANES; l++) begin
        r1_q[0][l]  <= {7'd0, d2_q[l][31:6]};
        nlo_q[0][l] <= {d2_q[l][5:0], 16'd0};
      end
      q1_q[0]  <= '0;
      ovf_q[0] <= ovf_d;
      den_q[0] <= den0_q;
      for (int j = 1; j <= D1; j++) begin
        r1_q[j]  <= r1_d[j];
        q1_q[j]  <= q1_d[j];
        nlo_q[j] <= nlo_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        den_q[j] <= den_q[j-1];
      end

      u_q <= u_d;
      for (int l = 0; l < LANES; l++) k1_q[l] <= u_q[l][22:16];
      ta_q   <= ta_d;
      prod_q <= prod_d;
      k2_q   <= k1_q;
      m_q    <= m_d;
      k3_q   <= k2_q;
      for (int l = 0; l < LANES; l++) num_q[l] <= 40'(m_q[l]) * 40'(INV_S2PI);

      r2_q[0] <= '0;
      n2_q[0] <= sh_d;
      q2_q[0] <= '0;
      for (int j = 1; j <= D2; j++) begin
        r2_q[j] <= r2_d[j];
        q2_q[j] <= q2_d[j];
        n2_q[j] <= n2_q[j-1];
      end

      out_q <= out_d;
    end
  end

  `GPDF_ASSERT_NOW(a_sat_clamps, out_valid_q && out_q.saturated, out_q.pdf0 == PDF_MAX || out_q.pdf1 == PDF_MAX || out_q.pdf2 == PDF_MAX || out_q.pdf3 == PDF_MAX)
  `GPDF_ASSERT_NEXT(a_accept_enters, valid_i && !stall_o, vld_q[0])
  `GPDF_ASSERT_NEXT(a_freeze, stall_o, $stable(vld_q) && out_valid_q)
  `GPDF_ASSERT_NEXT(a_drain, vld_q[NV-1] && adv, out_valid_q)

endmodule
